>>> hw/rtl/dsd_pkg.sv
package dsd_pkg;

  localparam int unsigned DEF_MAX_SEEDS    = 1024;
  localparam int unsigned DEF_MAX_PAIRS    = 8192;
  localparam int unsigned DEF_MEAS_ID_BITS = 20;

  localparam int unsigned SEED_W  = 11;
  localparam int unsigned SIDX_W  = 10;
  localparam int unsigned MID_W   = 20;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned KIND_W  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_HIT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NEWTRK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MEAS   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

  localparam logic REG_ENABLED    = 1'b0;
  localparam logic REG_SEED_COUNT = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_HIT,
    OP_END,
    OP_NEWTRK,
    OP_MEAS,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SIDX_W-1:0] sidx;
  } item_t;

endpackage

>>> hw/rtl/dsd_front.sv
module dsd_front #(
  parameter int unsigned KW = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       enabled,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dsd_pkg::KIND_W-1:0] kind,
  input  logic [dsd_pkg::MID_W-1:0]  measurement_id,
  input  logic [dsd_pkg::SIDX_W-1:0] seed_index,
  output logic                       q_valid,
  output dsd_pkg::item_t             q_item,
  output logic [KW-1:0]              q_key,
  input  logic                       q_take
);
  import dsd_pkg::*;

  item_t       fifo_item [2];
  logic [KW-1:0] fifo_key [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  item_t       cls;
  logic        push;

  always_comb begin
    cls.sidx = seed_index;
    cls.op   = OP_NOP;
    if (enabled) begin
      case (kind)
        KIND_HIT:    cls.op = OP_HIT;
        KIND_END:    cls.op = OP_END;
        KIND_NEWTRK: cls.op = OP_NEWTRK;
        KIND_MEAS:   cls.op = OP_MEAS;
        KIND_QUERY:  cls.op = OP_QUERY;
        default:     cls.op = OP_NOP;
      endcase
    end
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo_item[rptr];
  assign q_key    = fifo_key[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_item[wptr] <= cls;
      fifo_key[wptr]  <= KW'(measurement_id);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_take) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, q_take};
    end
  end

endmodule

>>> hw/rtl/dsd_back.sv
module dsd_back #(
  parameter int unsigned MAX_SEEDS = 1024,
  parameter int unsigned MAX_PAIRS = 8192,
  parameter int unsigned KW        = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dsd_pkg::SEED_W-1:0] seed_count,
  input  logic                       q_valid,
  input  dsd_pkg::item_t             q_item,
  input  logic [KW-1:0]              q_key,
  output logic                       q_take,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_duplicate,
  output logic [dsd_pkg::SEED_W-1:0] seeds_so_far,
  output logic [dsd_pkg::ST_W-1:0]   status
);
  import dsd_pkg::*;

  localparam int unsigned SAW = $clog2(MAX_SEEDS);
  localparam int unsigned PAW = $clog2(MAX_PAIRS);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_HIT, S_QRY, S_WIPE, S_SCAN_A, S_SCAN_B
  } state_t;

  state_t state;

  logic [KW-1:0]     pair_meas [MAX_PAIRS];
  logic [SEED_W-1:0] pair_seed [MAX_PAIRS];
  logic [CNT_W-1:0]  hit_mem   [MAX_SEEDS];
  logic [CNT_W-1:0]  used_mem  [MAX_SEEDS];
  logic              dup_mem   [MAX_SEEDS];

  logic [SAW-1:0]    clr_addr;
  logic [PAW:0]      pair_fill;
  logic [SEED_W-1:0] seeds_closed;
  logic [SEED_W-1:0] nes;
  logic              any_found;
  logic [PAW-1:0]    idx;
  logic [SEED_W-1:0] wipe_addr;
  logic [SEED_W-1:0] seed_sel;
  logic [KW-1:0]     key_reg;
  logic [ST_W-1:0]   scan_st;

  logic [KW-1:0]     pm_q;
  logic [SEED_W-1:0] ps_q;
  logic [CNT_W-1:0]  hit_q;
  logic [CNT_W-1:0]  used_q;
  logic              dup_q;

  logic [SEED_W-1:0] n;
  logic [SEED_W-1:0] sidx_ext;
  logic              last;
  logic              match;
  logic              go_b;
  logic              full;
  logic [CNT_W-1:0]  used_new;
  logic [PAW-1:0]    pair_raddr;
  logic [SAW-1:0]    seed_raddr;

  logic              hit_we;
  logic [SAW-1:0]    hit_waddr;
  logic [CNT_W-1:0]  hit_wdata;
  logic              used_we;
  logic [SAW-1:0]    used_waddr;
  logic [CNT_W-1:0]  used_wdata;
  logic              dup_we;
  logic [SAW-1:0]    dup_waddr;
  logic              dup_wdata;
  logic              pair_we;

  assign n = ({21'd0, seed_count} < 32'(MAX_SEEDS)) ? seed_count : SEED_W'(MAX_SEEDS);
  assign sidx_ext = {1'b0, q_item.sidx};
  assign last     = (({1'b0, idx} + 1'b1) == pair_fill);
  assign match    = (pm_q == key_reg);
  assign go_b     = match && (ps_q < n) && (ps_q >= nes);
  assign full     = (pair_fill == (PAW+1)'(MAX_PAIRS));
  assign used_new = (used_q < CNT_MAX) ? used_q + 1'b1 : used_q;
  assign q_take   = (state == S_IDLE) && q_valid && !out_valid;
  assign seeds_so_far = seeds_closed;

  always_comb begin
    pair_raddr = idx;
    seed_raddr = SAW'(ps_q);
    case (state)
      S_IDLE: begin
        pair_raddr = '0;
        if (q_item.op == OP_QUERY) seed_raddr = SAW'(sidx_ext);
        else seed_raddr = SAW'(seeds_closed);
      end
      S_SCAN_A: if (!go_b) pair_raddr = idx + 1'b1;
      S_SCAN_B: pair_raddr = idx + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    pair_we    = (state == S_HIT) && (hit_q < CNT_MAX) && !full;
    hit_we     = 1'b0;
    hit_waddr  = SAW'(seeds_closed);
    hit_wdata  = hit_q + 1'b1;
    used_we    = 1'b0;
    used_waddr = SAW'(seed_sel);
    used_wdata = used_new;
    dup_we     = 1'b0;
    dup_waddr  = SAW'(seed_sel);
    dup_wdata  = 1'b1;
    case (state)
      S_CLR: begin
        hit_we = 1'b1;  hit_waddr  = clr_addr; hit_wdata  = '0;
        used_we = 1'b1; used_waddr = clr_addr; used_wdata = '0;
        dup_we = 1'b1;  dup_waddr  = clr_addr; dup_wdata  = 1'b0;
      end
      S_HIT: hit_we = pair_we;
      S_WIPE: begin
        used_we = 1'b1; used_waddr = SAW'(wipe_addr); used_wdata = '0;
      end
      S_SCAN_B: begin
        used_we = !dup_q && (used_q < CNT_MAX);
        dup_we  = !dup_q && (used_new >= hit_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_meas[pair_fill[PAW-1:0]] <= key_reg;
      pair_seed[pair_fill[PAW-1:0]] <= seeds_closed;
    end
    pm_q <= pair_meas[pair_raddr];
    ps_q <= pair_seed[pair_raddr];
  end

  always_ff @(posedge clk) begin
    if (hit_we) hit_mem[hit_waddr] <= hit_wdata;
    if (used_we) used_mem[used_waddr] <= used_wdata;
    if (dup_we) dup_mem[dup_waddr] <= dup_wdata;
    hit_q  <= hit_mem[seed_raddr];
    used_q <= used_mem[seed_raddr];
    dup_q  <= dup_mem[seed_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      pair_fill    <= '0;
      seeds_closed <= '0;
      nes          <= '0;
      any_found    <= 1'b0;
      out_valid    <= 1'b0;
      is_duplicate <= 1'b0;
      status       <= ST_OK;
      idx          <= '0;
      wipe_addr    <= '0;
      seed_sel     <= '0;
      scan_st      <= ST_OK;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SAW'(MAX_SEEDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_take) begin
            key_reg      <= q_key;
            is_duplicate <= 1'b0;
            status       <= ST_OK;
            case (q_item.op)
              OP_HIT: begin
                if (seeds_closed >= n) begin
                  status    <= ST_RANGE;
                  out_valid <= 1'b1;
                end else begin
                  state <= S_HIT;
                end
              end
              OP_END: begin
                if (seeds_closed >= n) status <= ST_RANGE;
                else seeds_closed <= seeds_closed + 1'b1;
                out_valid <= 1'b1;
              end
              OP_NEWTRK: begin
                if (any_found && nes < n) begin
                  wipe_addr <= nes;
                  state     <= S_WIPE;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              OP_MEAS: begin
                idx     <= '0;
                scan_st <= ST_OK;
                if (nes == n || pair_fill == '0) out_valid <= 1'b1;
                else state <= S_SCAN_A;
              end
              OP_QUERY: begin
                if (sidx_ext >= n) begin
                  status    <= ST_RANGE;
                  out_valid <= 1'b1;
                end else begin
                  if (sidx_ext >= nes) nes <= sidx_ext + 1'b1;
                  state <= S_QRY;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_HIT: begin
          if (hit_q >= CNT_MAX) status <= ST_RANGE;
          else if (full) status <= ST_FULL;
          else pair_fill <= pair_fill + 1'b1;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_QRY: begin
          is_duplicate <= dup_q;
          out_valid    <= 1'b1;
          state        <= S_IDLE;
        end
        S_WIPE: begin
          wipe_addr <= wipe_addr + 1'b1;
          if (wipe_addr + 1'b1 == n) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_SCAN_A: begin
          seed_sel <= ps_q;
          if (go_b) begin
            state <= S_SCAN_B;
          end else begin
            // pair naming a seed beyond the live count
            if (match && ps_q >= n) scan_st <= ST_RANGE;
            if (last) begin
              status    <= (match && ps_q >= n) ? ST_RANGE : scan_st;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_SCAN_B: begin
          logic sat;
          sat = !dup_q && (used_q >= CNT_MAX);
          if (sat) scan_st <= ST_RANGE;
          if (!dup_q) any_found <= 1'b1;
          if (last) begin
            status    <= sat ? ST_RANGE : scan_st;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN_A;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/duplicate_seed_detector.sv
// seed end, rejected items and disabled items are answered straight from the idle state;
// seed hit and query pass through S_HIT or S_QRY; a clearing new trajectory wipes via S_WIPE
// measurement: scans stored pairs plus S_SCAN_B per matching live pair (one pair memory read port)
// the back end takes the next item only after the result beat
// a 2-beat input queue lets new items enter while the back end works
// reset (synchronous): clears all control state, then a sweep zeroes every seed table entry
module duplicate_seed_detector #(
  parameter int unsigned MAX_SEEDS    = dsd_pkg::DEF_MAX_SEEDS,
  parameter int unsigned MAX_PAIRS    = dsd_pkg::DEF_MAX_PAIRS,
  parameter int unsigned MEAS_ID_BITS = dsd_pkg::DEF_MEAS_ID_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [dsd_pkg::SEED_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dsd_pkg::KIND_W-1:0] kind,
  input  logic [dsd_pkg::MID_W-1:0]  measurement_id,
  input  logic [dsd_pkg::SIDX_W-1:0] seed_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_duplicate,
  output logic [dsd_pkg::SEED_W-1:0] seeds_so_far,
  output logic [dsd_pkg::ST_W-1:0]   status
);
  import dsd_pkg::*;

  logic              enabled;
  logic [SEED_W-1:0] seed_count;
  logic              q_valid;
  item_t             q_item;
  logic [MEAS_ID_BITS-1:0] q_key;
  logic              q_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b0;
      seed_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLED:    enabled    <= cfg_data[0];
        REG_SEED_COUNT: seed_count <= cfg_data;
        default: ;
      endcase
    end
  end

  dsd_front #(.KW(MEAS_ID_BITS)) u_front (
    .clk(clk), .rst(rst), .enabled(enabled),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .measurement_id(measurement_id), .seed_index(seed_index),
    .q_valid(q_valid), .q_item(q_item), .q_key(q_key), .q_take(q_take)
  );

  dsd_back #(.MAX_SEEDS(MAX_SEEDS), .MAX_PAIRS(MAX_PAIRS), .KW(MEAS_ID_BITS)) u_back (
    .clk(clk), .rst(rst), .seed_count(seed_count),
    .q_valid(q_valid), .q_item(q_item), .q_key(q_key), .q_take(q_take),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_duplicate(is_duplicate), .seeds_so_far(seeds_so_far), .status(status)
  );

endmodule

>>> tb/duplicate_seed_detector_checker.sv
`timescale 1ns / 100ps
module duplicate_seed_detector_checker
  import dsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [SEED_W-1:0]   cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [MID_W-1:0]    measurement_id,
  input  logic [SIDX_W-1:0]   seed_index,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                is_duplicate,
  input  logic [SEED_W-1:0]   seeds_so_far,
  input  logic [ST_W-1:0]     status,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic              dup;
    logic [SEED_W-1:0] closed;
    logic [ST_W-1:0]   st;
  } answer_t;

  localparam int NSEEDS = DEF_MAX_SEEDS;
  localparam int NPAIRS = DEF_MAX_PAIRS;

  logic              det_on;
  logic [SEED_W-1:0] slot_count;
  logic [MID_W-1:0]  pm [NPAIRS];
  logic [SIDX_W-1:0] ps [NPAIRS];
  int                fill;
  int                closed;
  logic [CNT_W-1:0]  hits [NSEEDS];
  logic [CNT_W-1:0]  used [NSEEDS];
  logic              dupf [NSEEDS];
  int                next_seed;
  logic              found;
  answer_t           answers [16];
  int                wr_cnt;
  int                rd_cnt;

  assign pending = wr_cnt - rd_cnt;

  function automatic answer_t score_item(logic [KIND_W-1:0] k, logic [MID_W-1:0] m,
                                         logic [SIDX_W-1:0] si);
    answer_t a;
    int n;
    int s;
    a.dup = 1'b0;
    a.st = ST_OK;
    n = (slot_count < NSEEDS) ? slot_count : NSEEDS;
    if (det_on) begin
      case (k)
        KIND_HIT: begin
          if (closed >= n) a.st = ST_RANGE;
          else if (hits[closed] >= CNT_MAX) a.st = ST_RANGE;
          else if (fill >= NPAIRS) a.st = ST_FULL;
          else begin
            pm[fill] = m;
            ps[fill] = closed[SIDX_W-1:0];
            fill++;
            hits[closed]++;
          end
        end
        KIND_END: begin
          if (closed >= n) a.st = ST_RANGE;
          else closed++;
        end
        KIND_NEWTRK: begin
          if (found && next_seed < n)
            for (int i = next_seed; i < n; i++) used[i] = '0;
        end
        KIND_MEAS: begin
          if (next_seed != n) begin
            for (int i = 0; i < fill; i++) begin
              if (pm[i] == m) begin
                s = ps[i];
                if (s >= n) a.st = ST_RANGE;
                else if (!(s < next_seed || dupf[s])) begin
                  if (used[s] >= CNT_MAX) a.st = ST_RANGE;
                  else used[s]++;
                  if (used[s] >= hits[s]) dupf[s] = 1'b1;
                  found = 1'b1;
                end
              end
            end
          end
        end
        KIND_QUERY: begin
          if (si >= n) a.st = ST_RANGE;
          else begin
            if (si >= next_seed) next_seed = si + 1;
            a.dup = dupf[si];
          end
        end
        default: ;
      endcase
    end
    a.closed = closed[SEED_W-1:0];
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      det_on <= 1'b0;
      slot_count <= '0;
      fill = 0;
      closed = 0;
      next_seed = 0;
      found = 1'b0;
      for (int i = 0; i < NSEEDS; i++) begin
        hits[i] = '0;
        used[i] = '0;
        dupf[i] = 1'b0;
      end
      wr_cnt = 0;
      rd_cnt = 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ENABLED) det_on <= cfg_data[0];
        else slot_count <= cfg_data;
      end
      if (in_valid && in_ready) begin
        answers[wr_cnt[3:0]] = score_item(kind, measurement_id, seed_index);
        wr_cnt++;
      end
      if (out_valid && out_ready) begin
        if (wr_cnt == rd_cnt) begin
          if (fail_count < 10) $display("unexpected result beat at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = answers[rd_cnt[3:0]];
          rd_cnt++;
          if (want != {is_duplicate, seeds_so_far, status}) begin
            if (fail_count < 10)
              $display("mismatch: expected dup %0d seeds %0d status %0d, got %0d %0d %0d",
                       want.dup, want.closed, want.st, is_duplicate, seeds_so_far, status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/duplicate_seed_detector_tb.sv
`timescale 1ns / 100ps
module duplicate_seed_detector_tb;
  import dsd_pkg::*;

  // a kind code the block does not define
  localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [SEED_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [KIND_W-1:0] kind;
  logic [MID_W-1:0]  measurement_id;
  logic [SIDX_W-1:0] seed_index;
  logic              out_valid;
  logic              out_ready;
  logic              is_duplicate;
  logic [SEED_W-1:0] seeds_so_far;
  logic [ST_W-1:0]   status;
  int                fail_count;
  int                pending;
  int                send_idle;
  int                recv_idle;
  longint            cycles;

  duplicate_seed_detector DUT (.*);
  duplicate_seed_detector_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run guard: a measurement beat scans every stored pair, so long runs end here with errors
  always @(posedge clk) begin
    if (rst) cycles <= 0;
    else cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(logic idx, logic [SEED_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_beat(logic [KIND_W-1:0] k, logic [MID_W-1:0] m, logic [SIDX_W-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    measurement_id <= m;
    seed_index <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // sends a random mix of hits, seed ends, new trajectories, measurements, queries and random kinds
  task automatic random_phase(int items, logic [MID_W-1:0] base);
    logic [MID_W-1:0] m;
    int r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      m = base + MID_W'($urandom_range(15));
      if ($urandom_range(19) == 0) m = MID_W'($urandom);
      if (r < 30) send_beat(KIND_HIT, m, SIDX_W'($urandom));
      else if (r < 42) send_beat(KIND_END, MID_W'($urandom), SIDX_W'($urandom));
      else if (r < 52) send_beat(KIND_NEWTRK, MID_W'($urandom), SIDX_W'($urandom));
      else if (r < 77) send_beat(KIND_MEAS, m, SIDX_W'($urandom));
      else if (r < 95)
        send_beat(KIND_QUERY, MID_W'($urandom), SIDX_W'($urandom_range(15)));
      else
        send_beat(KIND_W'($urandom_range(7)), MID_W'($urandom), SIDX_W'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_ENABLED;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_HIT;
    measurement_id = '0;
    seed_index = '0;
    send_idle = 32;
    recv_idle = 75;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // disabled: nothing changes
    write_reg(REG_SEED_COUNT, 11'd4);
    send_beat(KIND_HIT, 20'hFFFFF, 10'h3FF);
    send_beat(KIND_QUERY, '0, '0);
    drain();
    write_reg(REG_ENABLED, 11'd1);
    send_beat(KIND_HIT, 20'h00001, '0);
    send_beat(KIND_HIT, 20'hFFFFF, '0);
    send_beat(KIND_END, '0, '0);
    for (int i = 0; i < 16; i++) send_beat(KIND_HIT, 20'h00002, '0);
    send_beat(KIND_END, '0, '0);
    send_beat(KIND_MEAS, 20'h00001, '0);
    send_beat(KIND_MEAS, 20'hFFFFF, '0);
    send_beat(KIND_QUERY, '0, 10'd0);
    send_beat(KIND_QUERY, '0, 10'h3FF);
    send_beat(KIND_NEWTRK, '0, '0);
    for (int i = 0; i < 17; i++) send_beat(KIND_MEAS, 20'h00002, '0);
    send_beat(KIND_QUERY, '0, 10'd1);
    send_beat(KIND_SPARE, '0, '0);
    drain();
    // shrink the seed count below closed seeds
    write_reg(REG_SEED_COUNT, 11'd1);
    send_beat(KIND_END, '0, '0);
    send_beat(KIND_MEAS, 20'h00002, '0);
    send_beat(KIND_NEWTRK, '0, '0);
    drain();

    write_reg(REG_SEED_COUNT, 11'd2047);
    random_phase(20, 20'h00100);
    drain();
    send_idle = 75;
    recv_idle = 32;
    write_reg(REG_SEED_COUNT, 11'd12);
    random_phase(20, 20'hFFFE0);
    drain();
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_SEED_COUNT, 11'd0);
    random_phase(5, 20'h0);
    drain();
    write_reg(REG_SEED_COUNT, 11'd1024);
    random_phase(10, 20'h55550);
    drain();
    write_reg(REG_ENABLED, 11'd0);
    random_phase(5, 20'h0);
    drain();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> duplicate_seed_detector.f
hw/rtl/dsd_pkg.sv
hw/rtl/dsd_front.sv
hw/rtl/dsd_back.sv
hw/rtl/duplicate_seed_detector.sv
tb/duplicate_seed_detector_checker.sv
tb/duplicate_seed_detector_tb.sv
